// ----- rtl/ppc_pkg.sv -----
// ppc_pkg: shared constants, divider tables and types for the PWM prescaler/period block.
// No dependencies; imported by the interfaces and the top level.
package ppc_pkg;

   localparam int FREQ_W = 32;
   localparam int DUTY_W = 14;
   localparam int CODE_W = 3;
   localparam int CNT_W  = 16;
   localparam int NCODE  = 8;
   localparam int NPAIR  = NCODE * NCODE;
   localparam int NUM_W  = 38;

   // 1e9 ns per second, scaled for Q24.8 frequency
   localparam logic [63:0] NS_PER_S_Q8 = 64'd256000000000;
   localparam int DUTY_FULL = 10000;

   localparam int PERIOD_MAX_DEF = 65535;
   localparam int TICK_NS_DEF    = 10;

   localparam int PROD_W      = DUTY_W + CNT_W;
   localparam int RECIP_SHIFT = 43;
   localparam logic [31:0] DUTY_RECIP = 32'((64'd1 << RECIP_SHIFT) / DUTY_FULL);

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_CLAMP   = 2'd1,
      ST_UNREACH = 2'd2
   } status_type;

   typedef struct packed {
      logic [CODE_W-1:0] clk_code;
      logic [CODE_W-1:0] hsp_code;
      logic [DUTY_W-1:0] duty_a;
      logic [DUTY_W-1:0] duty_b;
      status_type        status;
   } side_type;

   function automatic int clk_mult(input int i);
      return 1 << i;
   endfunction

   function automatic int hsp_mult(input int j);
      return (j == 0) ? 1 : 2 * j;
   endfunction

   function automatic int product(input int i, input int j);
      return clk_mult(i) * hsp_mult(j);
   endfunction

   localparam int PROD_MAX = product(NCODE - 1, NCODE - 1);

   // largest divider product below p, zero if none
   function automatic int prev_product(input int p);
      int best;
      int pr;
      best = 0;
      for (int g = 0; g < NPAIR; g++) begin
         pr = product(g / NCODE, g % NCODE);
         if (pr < p && pr > best) best = pr;
      end
      return best;
   endfunction

   // true when no earlier pair in search order has the same product
   function automatic bit first_pair(input int i, input int j);
      bit res;
      res = 1'b1;
      for (int g = 0; g < i * NCODE + j; g++) begin
         if (product(g / NCODE, g % NCODE) == product(i, j)) res = 1'b0;
      end
      return res;
   endfunction

endpackage

// ----- rtl/ppc_if.sv -----
// ppc_if: valid/ready channels for request and response words.
// Depends on ppc_pkg.
interface ppc_req_if import ppc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] freq_hz_q8;
   logic [DUTY_W-1:0] duty_a;
   logic [DUTY_W-1:0] duty_b;

   modport source (output valid, freq_hz_q8, duty_a, duty_b, input ready);
   modport sink   (input valid, freq_hz_q8, duty_a, duty_b, output ready);
endinterface

interface ppc_rsp_if import ppc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] clock_div_code;
   logic [CODE_W-1:0] high_speed_div_code;
   logic [CNT_W-1:0]  period_count;
   logic [CNT_W-1:0]  compare_a;
   logic [CNT_W-1:0]  compare_b;
   logic [1:0]        status;

   modport source (output valid, clock_div_code, high_speed_div_code, period_count,
                   compare_a, compare_b, status, input ready);
   modport sink   (input valid, clock_div_code, high_speed_div_code, period_count,
                   compare_a, compare_b, status, output ready);
endinterface

// ----- rtl/pwm_prescaler_period_calc_top.sv -----
// pwm_prescaler_period_calc_top: divider pick, period divide and compare scaling, pipelined.
// Depends on ppc_pkg and ppc_if.
//
//   channel   dir  fields
//   req_ch    in   freq_hz_q8[31:0], duty_a[13:0], duty_b[13:0]
//   rsp_ch    out  clock_div_code, high_speed_div_code, period_count, compare_a,
//                  compare_b, status
//
// One word enters per cycle while the output is not stalled. Stages: register and
// clamp, divider pick, denominator, the one-bit-per-stage period divider (16 stages),
// then multiply and compare scaling stages. Reset clears only the stage valid bits.
// A stalled output holds the whole pipeline, bubbles included.
module pwm_prescaler_period_calc_top import ppc_pkg::*; #(
   parameter int PERIOD_MAX = PERIOD_MAX_DEF,
   parameter int TICK_NS    = TICK_NS_DEF
) (
   input logic       clock,
   input logic       reset,
   ppc_req_if.sink   req_ch,
   ppc_rsp_if.source rsp_ch
);

   localparam logic [63:0] K_SCALE     = 64'(PERIOD_MAX) * 64'(TICK_NS);
   localparam logic [63:0] UNREACH_MAX = (NS_PER_S_Q8 - 64'd1) / (K_SCALE * 64'(PROD_MAX));
   localparam int PT_W  = $clog2(TICK_NS * PROD_MAX + 1);
   localparam int DEN_W = FREQ_W + PT_W;
   localparam int CMP_W = DEN_W + CNT_W;

   logic adv;

   // stage 0: register and clamp
   logic              s0_vld_ff;
   logic [FREQ_W-1:0] s0_freq_ff;
   logic [DUTY_W-1:0] s0_da_ff, s0_db_ff;
   logic              s0_clamp_ff;

   // stage 1: divider pick
   logic              s1_vld_ff;
   logic [FREQ_W-1:0] s1_freq_ff;
   logic [PT_W-1:0]   s1_pt_ff;
   side_type          s1_side_ff;

   // divider stages
   logic              dv_vld_ff  [0:CNT_W];
   logic [NUM_W-1:0]  dv_rem_ff  [0:CNT_W];
   logic [CNT_W-1:0]  dv_quo_ff  [0:CNT_W];
   logic [DEN_W-1:0]  dv_den_ff  [0:CNT_W];
   side_type          dv_side_ff [0:CNT_W];

   // compare scaling
   logic              c1_vld_ff, c2_vld_ff, c3_vld_ff;
   logic [CNT_W-1:0]  c1_per_ff, c2_per_ff, c3_per_ff;
   logic [PROD_W-1:0] c1_xa_ff, c1_xb_ff, c2_xa_ff, c2_xb_ff;
   logic [PROD_W+31:0] c2_pa_ff, c2_pb_ff;
   logic [CNT_W-1:0]  c3_qa_ff, c3_qb_ff;
   logic              c3_inca_ff, c3_incb_ff;
   side_type          c1_side_ff, c2_side_ff, c3_side_ff;

   logic              out_vld_ff;
   logic [CODE_W-1:0] out_clk_ff, out_hsp_ff;
   logic [CNT_W-1:0]  out_per_ff, out_cmpa_ff, out_cmpb_ff;
   status_type        out_st_ff;

   assign adv          = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // ---------------- stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_ch.valid;
      end
      if (adv) begin
         s0_freq_ff  <= req_ch.freq_hz_q8;
         s0_da_ff    <= (req_ch.duty_a > DUTY_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                             : req_ch.duty_a;
         s0_db_ff    <= (req_ch.duty_b > DUTY_W'(DUTY_FULL)) ? DUTY_W'(DUTY_FULL)
                                                             : req_ch.duty_b;
         s0_clamp_ff <= (req_ch.duty_a > DUTY_W'(DUTY_FULL)) ||
                        (req_ch.duty_b > DUTY_W'(DUTY_FULL));
      end
   end

   // ---------------- stage 1: smallest product p with freq*K*p > 1e9*256
   logic [NPAIR-1:0]  sel;
   logic [63:0]       freq_ext;
   assign freq_ext = 64'(s0_freq_ff);

   for (genvar g = 0; g < NPAIR; g++) begin : g_pair
      localparam int  PI    = g / NCODE;
      localparam int  PJ    = g % NCODE;
      localparam int  P     = product(PI, PJ);
      localparam int  PP    = prev_product(P);
      localparam bit  FIRST = first_pair(PI, PJ);
      localparam logic [63:0] THR      = NS_PER_S_Q8 / (K_SCALE * 64'(P));
      localparam logic [63:0] THR_PREV =
         NS_PER_S_Q8 / (K_SCALE * 64'((PP == 0) ? 1 : PP));
      logic qual, qual_prev;
      assign qual      = freq_ext > THR;
      assign qual_prev = (PP != 0) && (freq_ext > THR_PREV);
      assign sel[g]    = FIRST && qual && !qual_prev;
   end

   logic [CODE_W-1:0] clk_sel, hsp_sel;
   logic [PT_W-1:0]   pt_sel;
   logic              unreach;

   always_comb begin
      clk_sel = CODE_W'(NCODE - 1);
      hsp_sel = CODE_W'(NCODE - 1);
      pt_sel  = PT_W'(TICK_NS * PROD_MAX);
      for (int g = 0; g < NPAIR; g++) begin
         if (sel[g]) begin
            clk_sel = CODE_W'(g / NCODE);
            hsp_sel = CODE_W'(g % NCODE);
            pt_sel  = PT_W'(TICK_NS * product(g / NCODE, g % NCODE));
         end
      end
   end

   assign unreach = freq_ext <= UNREACH_MAX;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s0_vld_ff;
      end
      if (adv) begin
         s1_freq_ff          <= s0_freq_ff;
         s1_pt_ff            <= pt_sel;
         s1_side_ff.clk_code <= clk_sel;
         s1_side_ff.hsp_code <= hsp_sel;
         s1_side_ff.duty_a   <= s0_da_ff;
         s1_side_ff.duty_b   <= s0_db_ff;
         s1_side_ff.status   <= unreach ? ST_UNREACH : (s0_clamp_ff ? ST_CLAMP : ST_OK);
      end
   end

   // ---------------- stage 2: denominator = freq * tick * product
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= s1_vld_ff;
      end
      if (adv) begin
         dv_den_ff[0]  <= DEN_W'(s1_freq_ff) * DEN_W'(s1_pt_ff);
         dv_rem_ff[0]  <= NUM_W'(NS_PER_S_Q8);
         dv_quo_ff[0]  <= '0;
         dv_side_ff[0] <= s1_side_ff;
      end
   end

   // ---------------- restoring divide, one quotient bit per stage
   for (genvar k = 1; k <= CNT_W; k++) begin : g_div
      localparam int B = CNT_W - k;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] rem_ext;
      logic             fits;
      assign trial   = CMP_W'(dv_den_ff[k-1]) << B;
      assign rem_ext = CMP_W'(dv_rem_ff[k-1]);
      assign fits    = rem_ext >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         if (adv) begin
            dv_rem_ff[k]  <= fits ? NUM_W'(rem_ext - trial) : dv_rem_ff[k-1];
            dv_quo_ff[k]  <= dv_quo_ff[k-1] | (fits ? (CNT_W'(1) << B) : '0);
            dv_den_ff[k]  <= dv_den_ff[k-1];
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // ---------------- compare = floor(period * duty / 10000) by reciprocal
   logic [PROD_W-1:0] rem_a, rem_b;
   logic [CNT_W-1:0]  q0_a, q0_b;
   assign q0_a  = CNT_W'(c2_pa_ff >> RECIP_SHIFT);
   assign q0_b  = CNT_W'(c2_pb_ff >> RECIP_SHIFT);
   assign rem_a = c2_xa_ff - PROD_W'(q0_a) * PROD_W'(DUTY_FULL);
   assign rem_b = c2_xb_ff - PROD_W'(q0_b) * PROD_W'(DUTY_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff  <= 1'b0;
         c2_vld_ff  <= 1'b0;
         c3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         c1_vld_ff  <= dv_vld_ff[CNT_W];
         c2_vld_ff  <= c1_vld_ff;
         c3_vld_ff  <= c2_vld_ff;
         out_vld_ff <= c3_vld_ff;
      end
      if (adv) begin
         c1_per_ff  <= dv_quo_ff[CNT_W];
         c1_xa_ff   <= PROD_W'(dv_quo_ff[CNT_W]) * PROD_W'(dv_side_ff[CNT_W].duty_a);
         c1_xb_ff   <= PROD_W'(dv_quo_ff[CNT_W]) * PROD_W'(dv_side_ff[CNT_W].duty_b);
         c1_side_ff <= dv_side_ff[CNT_W];

         c2_per_ff  <= c1_per_ff;
         c2_xa_ff   <= c1_xa_ff;
         c2_xb_ff   <= c1_xb_ff;
         c2_pa_ff   <= (PROD_W + 32)'(c1_xa_ff) * (PROD_W + 32)'(DUTY_RECIP);
         c2_pb_ff   <= (PROD_W + 32)'(c1_xb_ff) * (PROD_W + 32)'(DUTY_RECIP);
         c2_side_ff <= c1_side_ff;

         c3_per_ff  <= c2_per_ff;
         c3_qa_ff   <= q0_a;
         c3_qb_ff   <= q0_b;
         c3_inca_ff <= rem_a >= PROD_W'(DUTY_FULL);
         c3_incb_ff <= rem_b >= PROD_W'(DUTY_FULL);
         c3_side_ff <= c2_side_ff;

         out_st_ff <= c3_side_ff.status;
         if (c3_side_ff.status == ST_UNREACH) begin
            out_clk_ff  <= '0;
            out_hsp_ff  <= '0;
            out_per_ff  <= '0;
            out_cmpa_ff <= '0;
            out_cmpb_ff <= '0;
         end else begin
            out_clk_ff  <= c3_side_ff.clk_code;
            out_hsp_ff  <= c3_side_ff.hsp_code;
            out_per_ff  <= c3_per_ff;
            out_cmpa_ff <= c3_qa_ff + CNT_W'(c3_inca_ff);
            out_cmpb_ff <= c3_qb_ff + CNT_W'(c3_incb_ff);
         end
      end
   end

   assign rsp_ch.valid               = out_vld_ff;
   assign rsp_ch.clock_div_code      = out_clk_ff;
   assign rsp_ch.high_speed_div_code = out_hsp_ff;
   assign rsp_ch.period_count        = out_per_ff;
   assign rsp_ch.compare_a           = out_cmpa_ff;
   assign rsp_ch.compare_b           = out_cmpb_ff;
   assign rsp_ch.status              = out_st_ff;

   // ---------------- checks
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel))
      else $error("divider pick selected more than one pair");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_st_ff == ST_UNREACH) |->
         (out_per_ff == '0 && out_cmpa_ff == '0 && out_cmpb_ff == '0))
      else $error("unreachable word carries nonzero counts");

   a_cmp_le_period: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_cmpa_ff <= out_per_ff && out_cmpb_ff <= out_per_ff))
      else $error("compare value exceeds period");

endmodule
